// File: src/one_shot_timer_table_top_macros.svh
// Assertion helpers used by the checker file ostt_chk.sv.
`ifndef ONE_SHOT_TIMER_TABLE_TOP_MACROS_SVH
`define ONE_SHOT_TIMER_TABLE_TOP_MACROS_SVH

// Checked only outside reset.
`define OSTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OSTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ostt_pkg.sv
`default_nettype none

package ostt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int TICK_W     = 32;
    localparam int ENTRY_W    = 2 * TICK_W;

    typedef logic [2:0] t_status;
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_TICK   = 2'd0;
    localparam t_cmd CMD_CREATE = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    localparam t_status ST_CREATED      = 3'd0;
    localparam t_status ST_ZERO_TIMEOUT = 3'd1;
    localparam t_status ST_FULL         = 3'd2;
    localparam t_status ST_DELETED      = 3'd3;
    localparam t_status ST_NOT_ARMED    = 3'd4;
    localparam t_status ST_FIRED        = 3'd5;
    localparam t_status ST_NONE_FIRED   = 3'd6;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_SCAN = 3'b010,
        FSM_POST = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: src/ostt_ram.sv
`default_nettype none

module ostt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: src/one_shot_timer_table_top.sv
// One-shot timer table.
// Input stream: s_axis_tuser carries the command (tick, create, delete),
// s_axis_tdata the timeout and the slot to delete. Output stream: one item
// per input item, status in m_axis_tuser, slot and tick value in m_axis_tdata.
// Deadlines and creation stamps sit in one RAM with a registered read; armed
// bits are flops. Create, delete and the unused command go from IDLE to POST,
// where the result moves into the output register once that is free; the
// block then returns to IDLE and can take the next item. A tick reads every
// slot through the single RAM read port in SCAN to find the earliest due
// timer, then passes through POST in the same way.
// One item is in work at a time; s_axis_tready is high only when idle.
// The output register holds a finished item while the receiver stalls;
// a new input item is still taken meanwhile, and its result waits until
// the output register is free.
// Reset (synchronous, active low) clears the tick counter, the creation
// stamp counter, all armed bits and the output valid; RAM contents are
// left as they are and are used only for armed slots.
`default_nettype none

module one_shot_timer_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] timeout_ticks, [35:32] slot_handle
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // [3:0] slot, [35:4] tick_now
    output logic      [2:0]  m_axis_tuser   // [2:0] status
);

    localparam int N  = ostt_pkg::NUM_TIMERS;
    localparam int IW = ostt_pkg::IDX_W;
    localparam int CW = ostt_pkg::CNT_W;
    localparam int TW = ostt_pkg::TICK_W;
    localparam int EW = ostt_pkg::ENTRY_W;

    ostt_pkg::t_state r_state, n_state;
    logic [TW-1:0]    r_tick, n_tick;
    logic [TW-1:0]    r_stamp, n_stamp;
    logic [N-1:0]     r_armed, n_armed;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_rd_valid, n_rd_valid;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_found, n_found;
    logic [IW-1:0]    r_best_idx, n_best_idx;
    logic [TW-1:0]    r_best_dl, n_best_dl;
    logic [TW-1:0]    r_best_st, n_best_st;
    ostt_pkg::t_status r_res_status, n_res_status;
    logic [3:0]       r_res_slot, n_res_slot;
    logic             r_m_valid, n_m_valid;
    ostt_pkg::t_status r_m_status, n_m_status;
    logic [3:0]       r_m_slot, n_m_slot;
    logic [TW-1:0]    r_m_tick, n_m_tick;

    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic [EW-1:0]    rd_data;

    logic             free_any;
    logic [IW-1:0]    free_idx;

    ostt_pkg::t_cmd   in_cmd;
    logic [TW-1:0]    in_timeout;
    logic [3:0]       in_handle;
    logic [IW-1:0]    handle_idx;
    logic             handle_ok;
    logic [TW-1:0]    rd_dl;
    logic [TW-1:0]    rd_st;
    logic             accept;

    assign in_cmd     = s_axis_tuser;
    assign in_timeout = s_axis_tdata[31:0];
    assign in_handle  = s_axis_tdata[35:32];
    assign handle_idx = IW'(in_handle);
    assign handle_ok  = (32'(in_handle) < N) && r_armed[handle_idx];
    assign rd_dl      = rd_data[TW-1:0];
    assign rd_st      = rd_data[EW-1:TW];

    assign s_axis_tready = (r_state == ostt_pkg::FSM_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_armed[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    ostt_ram #(
        .WIDTH(EW),
        .DEPTH(N)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(r_addr[IW-1:0]),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_stamp      = r_stamp;
        n_armed      = r_armed;
        n_addr       = r_addr;
        n_rd_valid   = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_dl    = r_best_dl;
        n_best_st    = r_best_st;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_status   = r_m_status;
        n_m_slot     = r_m_slot;
        n_m_tick     = r_m_tick;
        wr_en        = 1'b0;
        wr_addr      = free_idx;
        wr_data      = {r_stamp, r_tick + in_timeout};

        unique case (r_state)
            ostt_pkg::FSM_IDLE: begin
                if (accept) begin
                    n_state    = ostt_pkg::FSM_POST;
                    n_res_slot = 4'd0;
                    priority if (in_cmd == ostt_pkg::CMD_TICK) begin
                        n_tick  = r_tick + 1'b1;
                        n_addr  = '0;
                        n_found = 1'b0;
                        n_state = ostt_pkg::FSM_SCAN;
                    end else if (in_cmd == ostt_pkg::CMD_CREATE) begin
                        priority if (in_timeout == '0) begin
                            n_res_status = ostt_pkg::ST_ZERO_TIMEOUT;
                        end else if (!free_any) begin
                            n_res_status = ostt_pkg::ST_FULL;
                        end else begin
                            wr_en             = 1'b1;
                            n_armed[free_idx] = 1'b1;
                            n_stamp           = r_stamp + 1'b1;
                            n_res_status      = ostt_pkg::ST_CREATED;
                            n_res_slot        = 4'(free_idx);
                        end
                    end else if (in_cmd == ostt_pkg::CMD_DELETE) begin
                        n_res_slot = in_handle;
                        if (handle_ok) begin
                            n_armed[handle_idx] = 1'b0;
                            n_res_status        = ostt_pkg::ST_DELETED;
                        end else begin
                            n_res_status = ostt_pkg::ST_NOT_ARMED;
                        end
                    end else begin
                        n_res_status = ostt_pkg::ST_NONE_FIRED;
                    end
                end
            end
            ostt_pkg::FSM_SCAN: begin
                // data for r_rd_idx arrives in the cycle after its address
                if (r_rd_valid && r_armed[r_rd_idx] && (rd_dl <= r_tick)) begin
                    if (!r_found || (rd_dl < r_best_dl) ||
                        ((rd_dl == r_best_dl) && (rd_st < r_best_st))) begin
                        n_found    = 1'b1;
                        n_best_idx = r_rd_idx;
                        n_best_dl  = rd_dl;
                        n_best_st  = rd_st;
                    end
                end
                if (r_addr != CW'(N)) begin
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_addr[IW-1:0];
                    n_addr     = r_addr + 1'b1;
                end else if (!r_rd_valid) begin
                    n_state = ostt_pkg::FSM_POST;
                    if (r_found) begin
                        n_armed[r_best_idx] = 1'b0;
                        n_res_status        = ostt_pkg::ST_FIRED;
                        n_res_slot          = 4'(r_best_idx);
                    end else begin
                        n_res_status = ostt_pkg::ST_NONE_FIRED;
                        n_res_slot   = 4'd0;
                    end
                end
            end
            ostt_pkg::FSM_POST: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_slot   = r_res_slot;
                    n_m_tick   = r_tick;
                    n_state    = ostt_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = ostt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ostt_pkg::FSM_IDLE;
            r_tick     <= '0;
            r_stamp    <= '0;
            r_armed    <= '0;
            r_rd_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_addr     <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_stamp    <= n_stamp;
            r_armed    <= n_armed;
            r_rd_valid <= n_rd_valid;
            r_m_valid  <= n_m_valid;
            r_addr     <= n_addr;
            r_found    <= n_found;
        end
        r_rd_idx     <= n_rd_idx;
        r_best_idx   <= n_best_idx;
        r_best_dl    <= n_best_dl;
        r_best_st    <= n_best_st;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_m_status   <= n_m_status;
        r_m_slot     <= n_m_slot;
        r_m_tick     <= n_m_tick;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {4'd0, r_m_tick, r_m_slot};

endmodule

`default_nettype wire

// File: src/ostt_chk.sv
`default_nettype none
`include "one_shot_timer_table_top_macros.svh"

module ostt_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    logic in_acc;
    logic slot_zero_kind;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign slot_zero_kind = (m_axis_tuser == ostt_pkg::ST_ZERO_TIMEOUT) ||
                            (m_axis_tuser == ostt_pkg::ST_FULL) ||
                            (m_axis_tuser == ostt_pkg::ST_NONE_FIRED);

    `OSTT_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `OSTT_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output item changed")
    `OSTT_ASSERT(a_status_code, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser != 3'd7) && (m_axis_tdata[39:36] == 4'd0), "bad status or pad bits")
    `OSTT_ASSERT(a_slot_zero, i_clk, i_rst_n, m_axis_tvalid && slot_zero_kind |-> (m_axis_tdata[3:0] == 4'd0), "slot not zero for slotless status")
    `OSTT_ASSERT(a_no_early_out, i_clk, i_rst_n, !in_acc && !m_axis_tvalid |=> !m_axis_tvalid || $past(s_axis_tready) == 1'b0, "result with no item in work")

endmodule

bind one_shot_timer_table_top ostt_chk u_ostt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_one_shot_timer_table_top.sv
module tb_one_shot_timer_table_top;
    import ostt_pkg::*;

    localparam t_cmd CMD_UNUSED = 2'd3;   // ignored by the block, still answered
    localparam int   N_RANDOM   = 700;
    localparam int   N_QUIET    = 100;    // tail of the run with no idling
    localparam int   RX_HOLDOFF = 300;
    localparam int   STUCK_MAX  = 4000;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic [31:0] tick;
    } t_result;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] tmo;
        logic [3:0]  hdl;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [31:0] timeout_ticks, [35:32] slot_handle
    logic [1:0]  s_axis_tuser = '0;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [3:0] slot, [35:4] tick_now
    logic [2:0]  m_axis_tuser;        // [2:0] status

    // typed-in expectation travelling alongside the item on offer
    bit          row_typed = 1'b0;
    t_result     row_want = '0;

    // shadow copy of the timer table
    logic [31:0] tick_cnt = '0;
    logic [31:0] stamp_ctr = '0;
    logic [31:0] due_at [NUM_TIMERS];
    logic [31:0] born [NUM_TIMERS];
    bit          live [NUM_TIMERS];

    t_result     pending_q [$];
    t_row        rows [$];
    int          n_errors = 0;
    int          n_taken = 0;
    int          stuck = 0;
    bit          quiet = 1'b0;

    one_shot_timer_table_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one command to the shadow table and returns the answer.
    function automatic t_result timer_table_step(t_cmd cmd, logic [31:0] tmo,
                                                 logic [3:0] hdl);
        t_result r;
        int      win;
        bit      placed;
        r = '{ST_NONE_FIRED, 4'd0, 32'd0};
        case (cmd)
            CMD_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
                win = -1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (live[i] && due_at[i] <= tick_cnt) begin
                        if (win < 0 || due_at[i] < due_at[win] ||
                            (due_at[i] == due_at[win] && born[i] < born[win]))
                            win = i;
                    end
                end
                if (win >= 0) begin
                    live[win] = 1'b0;
                    r.status = ST_FIRED;
                    r.slot = win[3:0];
                end
            end
            CMD_CREATE: begin
                if (tmo == 32'd0) begin
                    r.status = ST_ZERO_TIMEOUT;
                end else begin
                    r.status = ST_FULL;
                    placed = 1'b0;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (!placed && !live[i]) begin
                            placed = 1'b1;
                            live[i] = 1'b1;
                            due_at[i] = tick_cnt + tmo;
                            born[i] = stamp_ctr;
                            stamp_ctr = stamp_ctr + 32'd1;
                            r.status = ST_CREATED;
                            r.slot = i[3:0];
                        end
                    end
                end
            end
            CMD_DELETE: begin
                if (int'(hdl) < NUM_TIMERS && live[hdl]) begin
                    live[hdl] = 1'b0;
                    r.status = ST_DELETED;
                end else begin
                    r.status = ST_NOT_ARMED;
                end
                r.slot = hdl;
            end
            default: ;
        endcase
        r.tick = tick_cnt;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        n_errors++;
        $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    function automatic void add_row(t_cmd cmd, logic [31:0] tmo, logic [3:0] hdl,
                                    t_status st, logic [3:0] sl, logic [31:0] tk);
        t_row row;
        row.cmd = cmd;
        row.tmo = tmo;
        row.hdl = hdl;
        row.typed = 1'b1;
        row.want = '{st, sl, tk};
        rows.push_back(row);
    endfunction

    // row checked against the shadow table only
    function automatic void add_plain(t_cmd cmd, logic [31:0] tmo, logic [3:0] hdl);
        t_row row;
        row.cmd = cmd;
        row.tmo = tmo;
        row.hdl = hdl;
        row.typed = 1'b0;
        row.want = '0;
        rows.push_back(row);
    endfunction

    task automatic wait_drained;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // input side: every accepted item gets its answer queued
    always @(posedge i_clk) begin : take_mon
        t_result r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            r = timer_table_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[35:32]);
            if (row_typed)
                r = row_want;
            pending_q.push_back(r);
            n_taken++;
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                flag_mismatch("result with nothing pending, status",
                              32'(m_axis_tuser), 32'd0);
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tuser !== want.status)
                    flag_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[3:0] !== want.slot)
                    flag_mismatch("slot", 32'(m_axis_tdata[3:0]), 32'(want.slot));
                if (m_axis_tdata[35:4] !== want.tick)
                    flag_mismatch("tick_now", m_axis_tdata[35:4], want.tick);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck == STUCK_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // output side: random stalls, one long hold-off so the input backs up
    initial begin : rx_side
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held && n_taken >= 200) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLDOFF) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin : tx_side
        int          n_total;
        int          sel;
        int          pick;
        int          start;
        int          slot_i;
        bit          typed;
        bit          found;
        t_cmd        cmd;
        logic [31:0] tmo;
        logic [3:0]  hdl;
        t_result     want;

        for (int i = 0; i < NUM_TIMERS; i++) begin
            live[i] = 1'b0;
            due_at[i] = '0;
            born[i] = '0;
        end

        add_row(CMD_TICK,   32'd0,         4'd0,  ST_NONE_FIRED,   4'd0,  32'd1);
        add_row(CMD_CREATE, 32'd0,         4'hF,  ST_ZERO_TIMEOUT, 4'd0,  32'd1);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 4'hF,  ST_NONE_FIRED,   4'd0,  32'd1);
        // deadline wraps round to zero, so it is due on the very next tick
        add_row(CMD_CREATE, 32'hFFFF_FFFF, 4'd0,  ST_CREATED,      4'd0,  32'd1);
        add_plain(CMD_CREATE, 32'd2, 4'd0);
        add_row(CMD_TICK,   32'd0,         4'd0,  ST_FIRED,        4'd0,  32'd2);
        // slot 0 reused: same deadline as slot 1 but younger, so slot 1 wins
        add_plain(CMD_CREATE, 32'd1, 4'd0);
        add_plain(CMD_TICK,   32'd0, 4'd0);
        for (int i = 1; i < NUM_TIMERS; i++)
            add_plain(CMD_CREATE, 32'd1 << (2 * i), 4'd0);
        add_row(CMD_CREATE, 32'd5,         4'd0,  ST_FULL,         4'd0,  32'd3);
        add_plain(CMD_DELETE, 32'd0, 4'd15);
        add_row(CMD_DELETE, 32'd0,         4'd15, ST_NOT_ARMED,    4'd15, 32'd3);

        n_total = rows.size() + N_RANDOM;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < n_total; idx++) begin
            if (idx == rows.size() || idx == rows.size() + N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            quiet = (idx >= n_total - N_QUIET);
            typed = 1'b0;
            want = '0;
            if (idx < rows.size()) begin
                cmd = rows[idx].cmd;
                tmo = rows[idx].tmo;
                hdl = rows[idx].hdl;
                typed = rows[idx].typed;
                want = rows[idx].want;
            end else begin
                // unused fields carry noise
                tmo = $urandom;
                hdl = 4'($urandom_range(0, 15));
                sel = $urandom_range(0, 99);
                if (sel < 40) begin
                    cmd = CMD_TICK;
                end else if (sel < 72) begin
                    cmd = CMD_CREATE;
                    pick = $urandom_range(0, 19);
                    if (pick < 2)
                        tmo = 32'd0;
                    else if (pick < 4)
                        tmo = 32'hFFFF_FFFF - $urandom_range(0, 15);
                    else if (pick >= 7)
                        tmo = $urandom_range(1, 12);
                end else if (sel < 95) begin
                    cmd = CMD_DELETE;
                    // mostly aim at a live timer
                    if ($urandom_range(0, 3) != 0) begin
                        start = $urandom_range(0, NUM_TIMERS - 1);
                        found = 1'b0;
                        for (int k = 0; k < NUM_TIMERS; k++) begin
                            slot_i = (start + k) % NUM_TIMERS;
                            if (!found && live[slot_i]) begin
                                found = 1'b1;
                                hdl = slot_i[3:0];
                            end
                        end
                    end
                end else begin
                    cmd = CMD_UNUSED;
                end
            end

            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= cmd;
            s_axis_tdata <= {4'd0, hdl, tmo};
            row_typed <= typed;
            row_want <= want;
            do @(posedge i_clk); while (!s_axis_tready);

            if (!quiet && $urandom_range(0, 5) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
